### hw/rtl/i2c_bit_level_master_assert.svh
// Assertion macros for the checker of the I2C bit-level master.
// No dependencies; included by i2c_blm_checker.sv.
`ifndef I2C_BIT_LEVEL_MASTER_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_ASSERT_SVH

// Clocked property, switched off while reset is high.
`define I2C_BLM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define I2C_BLM_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/i2c_blm_pkg.sv
// Types and constants for the I2C bit-level master.
// No dependencies; used by i2c_blm_core, the top level and the checker.
package i2c_blm_pkg;

  localparam int unsigned HalfW = 16;

  localparam logic [HalfW-1:0] HALF_RESET = 16'd5;
  localparam logic [3:0]       BITS_PER_BYTE = 4'd8;

  // command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // done status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NACK = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] command;
    logic [7:0] write_byte;
    logic       sda_level;
    logic       scl_level;
  } in_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       ready_res;
    logic       done_res;
    logic [1:0] status;
  } out_t;

endpackage

### hw/rtl/i2c_blm_core.sv
// Line sequencer of the I2C bit-level master: phase state and next-state logic.
// Depends on i2c_blm_pkg.
module i2c_blm_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  i2c_blm_pkg::in_t                item,
  input  logic [i2c_blm_pkg::HalfW-1:0]   half_period,
  output i2c_blm_pkg::out_t               res
);

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_START_A   = 5'd1,
    PH_START_B   = 5'd2,
    PH_STOP_A    = 5'd3,
    PH_STOP_SCL  = 5'd4,
    PH_STOP_B    = 5'd5,
    PH_WR_SETUP  = 5'd6,
    PH_WR_HIGH   = 5'd7,
    PH_ACK_SETUP = 5'd8,
    PH_ACK_HIGH  = 5'd9,
    PH_ACK_LOW   = 5'd10
  } phase_t;

  phase_t                          phase, phase_next;
  logic [3:0]                      bit_count, bit_count_next;
  logic [7:0]                      shift_byte, shift_byte_next;
  logic [i2c_blm_pkg::HalfW-1:0]   hold_count, hold_count_next;
  logic                            scl_out, scl_out_next;
  logic                            sda_out, sda_out_next;

  logic [i2c_blm_pkg::HalfW-1:0]   half_ticks;
  logic                            expired;
  logic [3:0]                      bit_inc;
  logic                            done;
  logic [1:0]                      stat;

  // a zero half period behaves as one tick
  assign half_ticks = (half_period == '0) ? {{(i2c_blm_pkg::HalfW-1){1'b0}}, 1'b1}
                                          : half_period;
  assign expired = (hold_count <= {{(i2c_blm_pkg::HalfW-1){1'b0}}, 1'b1});
  assign bit_inc = bit_count + 4'd1;

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    scl_out_next    = scl_out;
    sda_out_next    = sda_out;
    done            = 1'b0;
    stat            = i2c_blm_pkg::ST_OK;
    // hold counts down in every timed phase; idle and stop-wait leave it
    if (phase == PH_IDLE || phase == PH_STOP_SCL) begin
      hold_count_next = hold_count;
    end else if (expired) begin
      hold_count_next = '0;
    end else begin
      hold_count_next = hold_count - {{(i2c_blm_pkg::HalfW-1){1'b0}}, 1'b1};
    end

    unique case (phase)
      PH_IDLE: begin
        if (item.cmd_valid) begin
          case (item.command)
            i2c_blm_pkg::CMD_START: begin
              sda_out_next    = 1'b1;
              scl_out_next    = 1'b1;
              phase_next      = PH_START_A;
              hold_count_next = half_ticks;
            end
            i2c_blm_pkg::CMD_STOP: begin
              sda_out_next    = 1'b0;
              scl_out_next    = 1'b1;
              phase_next      = PH_STOP_A;
              hold_count_next = half_ticks;
            end
            i2c_blm_pkg::CMD_WRITE: begin
              shift_byte_next = item.write_byte;
              bit_count_next  = 4'd0;
              sda_out_next    = item.write_byte[7];
              phase_next      = PH_WR_SETUP;
              hold_count_next = half_ticks;
            end
            default: ;
          endcase
        end
      end
      PH_START_A: begin
        if (expired) begin
          if (!item.sda_level) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
            stat       = i2c_blm_pkg::ST_BUSY;
          end else begin
            sda_out_next    = 1'b0;
            phase_next      = PH_START_B;
            hold_count_next = half_ticks;
          end
        end
      end
      PH_START_B: begin
        if (expired) begin
          scl_out_next = 1'b0;
          phase_next   = PH_IDLE;
          done         = 1'b1;
        end
      end
      PH_STOP_A: begin
        if (expired) phase_next = PH_STOP_SCL;
      end
      PH_STOP_SCL: begin
        // clock stretching: wait for the slave to let SCL go high
        if (item.scl_level) begin
          sda_out_next    = 1'b1;
          phase_next      = PH_STOP_B;
          hold_count_next = half_ticks;
        end
      end
      PH_STOP_B: begin
        if (expired) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
      end
      PH_WR_SETUP: begin
        if (expired) begin
          scl_out_next    = 1'b1;
          phase_next      = PH_WR_HIGH;
          hold_count_next = half_ticks;
        end
      end
      PH_WR_HIGH: begin
        if (expired) begin
          scl_out_next    = 1'b0;
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_count_next  = bit_inc;
          hold_count_next = half_ticks;
          if (bit_inc >= i2c_blm_pkg::BITS_PER_BYTE) begin
            sda_out_next = 1'b1;
            phase_next   = PH_ACK_SETUP;
          end else begin
            sda_out_next = shift_byte[6];
            phase_next   = PH_WR_SETUP;
          end
        end
      end
      PH_ACK_SETUP: begin
        if (expired) begin
          scl_out_next    = 1'b1;
          phase_next      = PH_ACK_HIGH;
          hold_count_next = half_ticks;
        end
      end
      PH_ACK_HIGH: begin
        if (expired) begin
          shift_byte_next = {7'd0, item.sda_level};
          scl_out_next    = 1'b0;
          phase_next      = PH_ACK_LOW;
          hold_count_next = half_ticks;
        end
      end
      PH_ACK_LOW: begin
        if (expired) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
          stat       = shift_byte[0] ? i2c_blm_pkg::ST_NACK : i2c_blm_pkg::ST_OK;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= 4'd0;
      shift_byte <= 8'd0;
      hold_count <= '0;
      scl_out    <= 1'b1;
      sda_out    <= 1'b1;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
      hold_count <= hold_count_next;
      scl_out    <= scl_out_next;
      sda_out    <= sda_out_next;
    end
  end

  assign res.scl_release = scl_out_next;
  assign res.sda_release = sda_out_next;
  assign res.ready_res   = (phase_next == PH_IDLE);
  assign res.done_res    = done;
  assign res.status      = stat;

endmodule

### hw/rtl/i2c_bit_level_master.sv
// Top level of the I2C bit-level master: input register, sequencer, result register.
// Depends on i2c_blm_pkg and i2c_blm_core.
//
// Open-drain I2C master driven by one request per time tick. Each request
// carries an optional command (start, stop, write byte), the byte to send and
// the sensed SDA/SCL levels; each request yields exactly one result with the
// line drive (1 = release, 0 = pull low), an idle flag, a done strobe and a
// status (ok/ack, nack, bus busy at start). Every timed line phase is held for
// half_period_ticks ticks, written through the cfg port (reset 5, 0 acts as
// 1); write it only while the sequencer is idle. Bytes go out MSB first and
// an SCL pulse after the last data bit samples ACK. Stop waits for SCL to read high, so a slave
// may stretch the clock. Commands offered while busy are ignored, as is the
// unused command code. Throughput is one request per clock while out_ready
// does not stall: the input register feeds the sequencer's next-state logic,
// whose result lands in the output register in the same cycle the state
// advances. A request passes from the input register to the result register;
// out_ready low stalls both stages, and a new request is still taken while the
// result register is full as long as the input register is free to move.
module i2c_bit_level_master (
  input  logic                            clk,
  input  logic                            rst,
  // tick requests
  input  logic                            in_valid,
  output logic                            in_ready,
  input  i2c_blm_pkg::in_t                in_data,
  // results, one per request
  output logic                            out_valid,
  input  logic                            out_ready,
  output i2c_blm_pkg::out_t               out_data,
  // half-period register
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [i2c_blm_pkg::HalfW-1:0]   cfg_data
);

  logic                            s1_valid;
  i2c_blm_pkg::in_t                s1_data;
  logic [i2c_blm_pkg::HalfW-1:0]   half_period;
  logic                            adv;
  i2c_blm_pkg::out_t               res;

  // stage 1 moves into the result register when that register is free
  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      half_period <= i2c_blm_pkg::HALF_RESET;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
        s1_data  <= in_data;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) half_period <= cfg_data;
    end
  end

  // sequencer state advances once per request, together with the result
  i2c_blm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (adv),
    .item        (s1_data),
    .half_period (half_period),
    .res         (res)
  );

endmodule

### hw/rtl/i2c_blm_checker.sv
// Port-level assertions for the I2C bit-level master, bound to the top level.
// Depends on i2c_blm_pkg and i2c_bit_level_master_assert.svh.
`include "i2c_bit_level_master_assert.svh"

module i2c_blm_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input i2c_blm_pkg::out_t out_data
);

  `I2C_BLM_ASSERT_RST(a_reset_empty, clk, rst |=> !out_valid, "result valid after reset")

  `I2C_BLM_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  `I2C_BLM_ASSERT(a_done_idle, clk, rst, out_valid && out_data.done_res |-> out_data.ready_res, "done while not idle")

  `I2C_BLM_ASSERT(a_status_quiet, clk, rst, out_valid && !out_data.done_res |-> out_data.status == i2c_blm_pkg::ST_OK, "status without done")

  `I2C_BLM_ASSERT(a_busy_released, clk, rst, out_valid && out_data.done_res && out_data.status == i2c_blm_pkg::ST_BUSY |-> out_data.scl_release && out_data.sda_release, "bus busy with a line pulled")

endmodule

bind i2c_bit_level_master i2c_blm_checker u_chk (.*);

### tb/sv/i2c_blm_line_checker.sv
// Checker for the I2C bit-level master: follows the request, result and
// half-period channels, predicts each result and compares it field by field.
// Depends on i2c_blm_pkg.
module i2c_blm_line_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  i2c_blm_pkg::in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  i2c_blm_pkg::out_t             out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [i2c_blm_pkg::HalfW-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfW = i2c_blm_pkg::HalfW;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_START_REL,
    SEQ_START_PULL,
    SEQ_STOP_SETUP,
    SEQ_STOP_WAIT,
    SEQ_STOP_HOLD,
    SEQ_BIT_SETUP,
    SEQ_BIT_HIGH,
    SEQ_ACK_SETUP,
    SEQ_ACK_HIGH,
    SEQ_ACK_LOW
  } seq_phase_t;

  // predicted sequencer state
  logic [HalfW-1:0] half_reg;
  seq_phase_t       seq_ph;
  logic [3:0]       bit_cnt;
  logic [7:0]       shreg;
  logic [HalfW-1:0] hold_left;
  logic             scl_drv;
  logic             sda_drv;

  i2c_blm_pkg::out_t bus_results_due[$];
  int                results_checked;

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [1:0] got, input logic [1:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                              results_checked, name, got, want));
    end
  endtask

  function automatic void enter_phase(input seq_phase_t next);
    seq_ph    = next;
    hold_left = (half_reg == '0) ? HalfW'(1) : half_reg;
  endfunction

  // true on the tick the current phase's hold runs out
  function automatic logic hold_expired();
    if (hold_left > HalfW'(1)) begin
      hold_left--;
      return 1'b0;
    end
    hold_left = '0;
    return 1'b1;
  endfunction

  // one tick of the line sequencer; returns the line drive and status after it
  function automatic i2c_blm_pkg::out_t advance_bus(input i2c_blm_pkg::in_t t);
    i2c_blm_pkg::out_t r;
    logic              finished;
    logic [1:0]        code;
    finished = 1'b0;
    code     = i2c_blm_pkg::ST_OK;
    case (seq_ph)
      SEQ_IDLE: begin
        if (t.cmd_valid) begin
          if (t.command == i2c_blm_pkg::CMD_START) begin
            sda_drv = 1'b1;
            scl_drv = 1'b1;
            enter_phase(SEQ_START_REL);
          end else if (t.command == i2c_blm_pkg::CMD_STOP) begin
            sda_drv = 1'b0;
            scl_drv = 1'b1;
            enter_phase(SEQ_STOP_SETUP);
          end else if (t.command == i2c_blm_pkg::CMD_WRITE) begin
            shreg   = t.write_byte;
            bit_cnt = '0;
            sda_drv = t.write_byte[7];
            enter_phase(SEQ_BIT_SETUP);
          end
        end
      end
      SEQ_START_REL: begin
        if (hold_expired()) begin
          if (!t.sda_level) begin
            seq_ph   = SEQ_IDLE;
            finished = 1'b1;
            code     = i2c_blm_pkg::ST_BUSY;
          end else begin
            sda_drv = 1'b0;
            enter_phase(SEQ_START_PULL);
          end
        end
      end
      SEQ_START_PULL: begin
        if (hold_expired()) begin
          scl_drv  = 1'b0;
          seq_ph   = SEQ_IDLE;
          finished = 1'b1;
        end
      end
      SEQ_STOP_SETUP: begin
        if (hold_expired()) seq_ph = SEQ_STOP_WAIT;
      end
      SEQ_STOP_WAIT: begin
        if (t.scl_level) begin
          sda_drv = 1'b1;
          enter_phase(SEQ_STOP_HOLD);
        end
      end
      SEQ_STOP_HOLD: begin
        if (hold_expired()) begin
          seq_ph   = SEQ_IDLE;
          finished = 1'b1;
        end
      end
      SEQ_BIT_SETUP: begin
        if (hold_expired()) begin
          scl_drv = 1'b1;
          enter_phase(SEQ_BIT_HIGH);
        end
      end
      SEQ_BIT_HIGH: begin
        if (hold_expired()) begin
          scl_drv = 1'b0;
          shreg   = shreg << 1;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= i2c_blm_pkg::BITS_PER_BYTE) begin
            sda_drv = 1'b1;
            enter_phase(SEQ_ACK_SETUP);
          end else begin
            sda_drv = shreg[7];
            enter_phase(SEQ_BIT_SETUP);
          end
        end
      end
      SEQ_ACK_SETUP: begin
        if (hold_expired()) begin
          scl_drv = 1'b1;
          enter_phase(SEQ_ACK_HIGH);
        end
      end
      SEQ_ACK_HIGH: begin
        if (hold_expired()) begin
          shreg   = {7'd0, t.sda_level};
          scl_drv = 1'b0;
          enter_phase(SEQ_ACK_LOW);
        end
      end
      SEQ_ACK_LOW: begin
        if (hold_expired()) begin
          seq_ph   = SEQ_IDLE;
          finished = 1'b1;
          code     = shreg[0] ? i2c_blm_pkg::ST_NACK : i2c_blm_pkg::ST_OK;
        end
      end
      default: begin
        seq_ph = SEQ_IDLE;
      end
    endcase
    r.scl_release = scl_drv;
    r.sda_release = sda_drv;
    r.ready_res   = (seq_ph == SEQ_IDLE);
    r.done_res    = finished;
    r.status      = code;
    return r;
  endfunction

  always @(posedge clk) begin
    i2c_blm_pkg::out_t want;
    if (rst) begin
      half_reg  = i2c_blm_pkg::HALF_RESET;
      seq_ph    = SEQ_IDLE;
      bit_cnt   = '0;
      shreg     = '0;
      hold_left = '0;
      scl_drv   = 1'b1;
      sda_drv   = 1'b1;
      bus_results_due.delete();
      results_checked = 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) half_reg = cfg_data;
      if (in_valid && in_ready) bus_results_due.push_back(advance_bus(in_data));
      if (out_valid && out_ready) begin
        if (bus_results_due.size() == 0) begin
          note_mismatch("result with no request outstanding");
        end else begin
          want = bus_results_due.pop_front();
          check_field("scl_release", out_data.scl_release, want.scl_release);
          check_field("sda_release", out_data.sda_release, want.sda_release);
          check_field("ready_res", out_data.ready_res, want.ready_res);
          check_field("done_res", out_data.done_res, want.done_res);
          check_field("status", out_data.status, want.status);
        end
        results_checked++;
      end
      pending <= bus_results_due.size();
    end
  end

endmodule

### tb/sv/i2c_bit_level_master_tb.sv
// Top of the I2C bit-level master testbench: clock, reset, tick stimulus,
// result back-pressure and the verdict.
// Depends on i2c_blm_pkg, i2c_bit_level_master and i2c_blm_line_checker.
module i2c_bit_level_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfW = i2c_blm_pkg::HalfW;

  // the fourth command code; the sequencer must ignore it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // random part runs until both are reached
  localparam int unsigned RandTicks   = 500;
  localparam int unsigned MinRandCmds = 12;

  // how the sensed SDA level behaves while a command runs
  typedef enum logic [1:0] {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_mode_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  i2c_blm_pkg::in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  i2c_blm_pkg::out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [HalfW-1:0]  cfg_data  = '0;

  int fail_count;
  int pending;

  bit               gaps_on      = 1'b1;  // random idling on both channels
  int               stall_left   = 0;
  int unsigned      ticks_sent   = 0;     // requests accepted so far
  int unsigned      results_seen = 0;     // results accepted so far
  logic             last_idle    = 1'b1;  // ready_res of the newest result
  int unsigned      cmds_issued  = 0;
  logic [HalfW-1:0] half_now     = i2c_blm_pkg::HALF_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_bit_level_master DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  i2c_blm_line_checker u_line_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result back-pressure: stall bursts of random length while gaps are on.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Track the newest result so the stimulus knows when the sequencer is back
  // to idle. Results come in request order, so result N belongs to request N.
  always @(posedge clk) begin
    if (rst) begin
      results_seen <= 0;
      last_idle    <= 1'b1;
    end else if (out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      last_idle    <= out_data.ready_res;
    end
  end

  // Offer one tick request and hold it until accepted. Valid stays high on
  // return; the caller either offers the next request in the same step or
  // parks the channel.
  task automatic send_tick(input i2c_blm_pkg::in_t t);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // A tick with random content. With may_offer low it never carries a
  // command; with it high it may, which is only safe while the sequencer is
  // known to be busy. SCL reads low a quarter of the time, so a stop sees a
  // stretched clock now and then.
  function automatic i2c_blm_pkg::in_t filler_tick(input bit may_offer, input sda_mode_t mode);
    i2c_blm_pkg::in_t t;
    t.cmd_valid  = may_offer ? 1'($urandom_range(0, 1)) : 1'b0;
    t.command    = 2'($urandom_range(0, 3));
    t.write_byte = 8'($urandom_range(0, 255));
    case (mode)
      SDA_HIGH: t.sda_level = 1'b1;
      SDA_LOW:  t.sda_level = 1'b0;
      default:  t.sda_level = 1'($urandom_range(0, 1));
    endcase
    t.scl_level  = ($urandom_range(0, 3) != 0);
    return t;
  endfunction

  // Number of command-bearing ticks that may follow a command and still be
  // ignored: every start, stop or write keeps the sequencer busy for at least one half
  // period after it is taken.
  function automatic int unsigned noise_len();
    int unsigned cap;
    cap = (half_now == '0) ? 1 : ((half_now > 6) ? 6 : half_now);
    return $urandom_range(0, cap);
  endfunction

  // Issue a command to the idle sequencer, follow it with 'noise' ticks that
  // offer commands while busy, then keep ticking quietly until a result at
  // or after the command shows the sequencer idle again.
  task automatic do_command(input logic [1:0] code, input logic [7:0] wbyte,
                            input sda_mode_t mode, input int unsigned noise);
    i2c_blm_pkg::in_t t;
    int unsigned      mark;
    t            = filler_tick(1'b0, mode);
    t.cmd_valid  = 1'b1;
    t.command    = code;
    t.write_byte = wbyte;
    send_tick(t);
    mark = ticks_sent;
    repeat (noise) send_tick(filler_tick(1'b1, mode));
    while (!(results_seen >= mark && last_idle)) send_tick(filler_tick(1'b0, mode));
    cmds_issued++;
  endtask

  // Stop offering requests and wait until every result has come back.
  task automatic park();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Change the half period; only done with the sequencer idle and drained.
  task automatic set_half(input logic [HalfW-1:0] value);
    park();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    half_now = value;
  endtask

  initial begin
    int unsigned      rand_base;
    logic [HalfW-1:0] h;
    logic [1:0]       code;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset half period first.
    do_command(i2c_blm_pkg::CMD_START, 8'h00, SDA_HIGH, 0);     // clean start
    do_command(i2c_blm_pkg::CMD_START, 8'hFF, SDA_LOW, 2);      // SDA held low: bus busy
    do_command(i2c_blm_pkg::CMD_WRITE, 8'h00, SDA_LOW, 3);      // all zeros, acked
    do_command(i2c_blm_pkg::CMD_WRITE, 8'hFF, SDA_HIGH, 5);     // all ones, nacked
    do_command(i2c_blm_pkg::CMD_WRITE, 8'hA5, SDA_RANDOM, 1);
    do_command(i2c_blm_pkg::CMD_STOP, 8'h00, SDA_RANDOM, 4);    // may see SCL stretched
    do_command(CMD_UNUSED, 8'h3C, SDA_RANDOM, 0);               // ignored, stays idle

    // Shortest half period.
    set_half(16'd1);
    do_command(i2c_blm_pkg::CMD_START, 8'h12, SDA_HIGH, 1);
    do_command(i2c_blm_pkg::CMD_WRITE, 8'h5A, SDA_RANDOM, 1);
    do_command(i2c_blm_pkg::CMD_WRITE, 8'h80, SDA_LOW, 0);
    do_command(i2c_blm_pkg::CMD_STOP, 8'hC3, SDA_RANDOM, 1);
    do_command(i2c_blm_pkg::CMD_START, 8'h00, SDA_LOW, 1);      // busy with one-tick phases

    // Zero behaves as one.
    set_half(16'd0);
    do_command(i2c_blm_pkg::CMD_START, 8'h00, SDA_HIGH, 1);
    do_command(i2c_blm_pkg::CMD_WRITE, 8'h81, SDA_HIGH, 1);
    do_command(i2c_blm_pkg::CMD_STOP, 8'hFF, SDA_RANDOM, 0);

    // Long half period that reaches the upper count bits; a busy start keeps
    // it to a single phase.
    set_half(16'h0100);
    do_command(i2c_blm_pkg::CMD_START, 8'h7E, SDA_LOW, 6);

    // Random part: mostly well-formed frames (start, a few bytes, stop) with
    // random bytes and ack levels, some lone commands, under changing half
    // periods. The last stretch runs without idling.
    rand_base   = ticks_sent;
    cmds_issued = 0;
    while (ticks_sent - rand_base < RandTicks || cmds_issued < MinRandCmds) begin
      gaps_on = (ticks_sent - rand_base < RandTicks * 8 / 10) &&
                ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       h = 16'd0;
        1, 2:    h = 16'd1;
        3, 4:    h = 16'd2;
        5:       h = 16'd3;
        default: h = HalfW'($urandom_range(4, 12));
      endcase
      set_half(h);
      repeat ($urandom_range(3, 6)) begin
        if ($urandom_range(0, 4) != 0) begin
          // start usually sees a free bus; now and then SDA is random
          do_command(i2c_blm_pkg::CMD_START, 8'($urandom_range(0, 255)),
                     ($urandom_range(0, 9) == 0) ? SDA_RANDOM : SDA_HIGH, noise_len());
          repeat ($urandom_range(0, 3)) begin
            do_command(i2c_blm_pkg::CMD_WRITE, 8'($urandom_range(0, 255)), SDA_RANDOM,
                       noise_len());
          end
          do_command(i2c_blm_pkg::CMD_STOP, 8'($urandom_range(0, 255)), SDA_RANDOM,
                     noise_len());
        end else begin
          // lone command in any order, any code, any SDA behavior
          code = 2'($urandom_range(0, 3));
          do_command(code, 8'($urandom_range(0, 255)), sda_mode_t'($urandom_range(0, 2)),
                     (code == CMD_UNUSED) ? 0 : noise_len());
        end
      end
    end

    // Drain, then keep clocking so that anything unexpected can still show up.
    park();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: the slowest correct run, with the longest idling around every
  // request, is well under a fifth of this.
  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/i2c_blm_pkg.sv
hw/rtl/i2c_blm_core.sv
hw/rtl/i2c_bit_level_master.sv
hw/rtl/i2c_blm_checker.sv
tb/sv/i2c_blm_line_checker.sv
tb/sv/i2c_bit_level_master_tb.sv
